>>> rtl/lpp_pkg.sv
// lpp_pkg: widths, register indexes, reset values, sequencer codes and
// helper functions of the lead-predicting pan aim loop.
// No dependencies; every other file of the block imports it.
package lpp_pkg;

  // field widths
  localparam int POS_W      = 16;
  localparam int TIME_W     = 32;
  localparam int DT_W       = 10;
  localparam int GAIN_W     = 16;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int ACC_W      = 56;   // accumulator, dividend and quotient
  localparam int MPL_W      = 21;   // serial multiplier operand
  localparam int DEN_W      = 21;   // divisor
  localparam int REM_W      = 22;   // partial remainder
  localparam int VEL_W      = 32;   // velocity and acceleration
  localparam int MAG_W      = 34;   // predicted position magnitude
  localparam int CX_W       = 32;   // rotator x and y
  localparam int Z_W        = 26;   // angle accumulator, 1/65536 degree
  localparam int ATAN_W     = 22;
  localparam int ATAN_IDX_W = 5;
  localparam int CNT_W      = 6;
  localparam int CORDIC_STEPS_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd7;

  // reset values
  localparam logic [GAIN_W-1:0]       KP_RST       = 16'd256;
  localparam logic [GAIN_W-1:0]       KD_RST       = 16'd0;
  localparam logic [DT_W-1:0]         LEAD_RST     = 10'd100;
  localparam logic [DT_W-1:0]         FALLBACK_RST = 10'd20;
  localparam logic signed [ANG_W-1:0] CENTER_RST   = 16'sd11520;
  localparam logic signed [ANG_W-1:0] MIN_PAN_RST  = 16'sd0;
  localparam logic signed [ANG_W-1:0] MAX_PAN_RST  = 16'sd23040;

  // arithmetic constants
  localparam logic [TIME_W-1:0]       DT_MAX    = 32'd1000;
  localparam logic [DEN_W-1:0]        PRED_DIV  = 21'd2000000;
  localparam logic [DEN_W-1:0]        STEP_DIV  = 21'd256000;
  localparam logic signed [Z_W-1:0]   HALF_TURN = 26'sd11796480;
  localparam logic [Z_W-1:0]          Z_ROUND   = 26'd256;
  localparam int                      Z_SHIFT   = 9;
  localparam int                      NORM_HI   = 29;
  localparam int                      NORM_LO   = 28;
  localparam logic signed [ANG_W-1:0] PAN_MAX   = 16'sh7fff;
  localparam logic signed [ANG_W-1:0] PAN_MIN   = 16'sh8000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MACLD, ST_MAC, ST_DIVLD, ST_DIV, ST_WB,
    ST_CLD, ST_CNORM, ST_CPREP, ST_CITER, ST_AIM, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_VX, OP_VY, OP_AX, OP_AY, OP_PX, OP_PY, OP_STEP
  } op_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117306;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // times 1000 as 1024 - 16 - 8
  function automatic logic signed [ACC_W-1:0] times1000(input logic signed [ACC_W-1:0] a);
    return (a <<< 10) - (a <<< 4) - (a <<< 3);
  endfunction

  // saturate a sign-magnitude quotient to 32 bits signed
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic neg,
                                                       input logic [ACC_W-1:0] q);
    logic over_pos;
    logic over_neg;
    over_pos = |q[ACC_W-1:VEL_W-1];
    over_neg = (|q[ACC_W-1:VEL_W]) || (q[VEL_W-1] && (|q[VEL_W-2:0]));
    if (!neg) begin
      return over_pos ? {1'b0, {(VEL_W-1){1'b1}}} : $signed(q[VEL_W-1:0]);
    end
    return over_neg ? {1'b1, {(VEL_W-1){1'b0}}} : -$signed(q[VEL_W-1:0]);
  endfunction

endpackage

>>> rtl/lpp_if.sv
// lpp_in_if and lpp_out_if: valid/ready request channels of the pan aim loop.
// Depends on lpp_pkg for the field widths.
interface lpp_in_if import lpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [TIME_W-1:0]        time_ms;

  modport source (output valid, output pos_x, output pos_y, output time_ms,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input time_ms,
                output ready);
endinterface

interface lpp_out_if import lpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  pan_angle;
  logic signed [ANG_W-1:0]  aim_angle;

  modport source (output valid, output pan_angle, output aim_angle, input ready);
  modport sink (input valid, input pan_angle, input aim_angle, output ready);
endinterface

>>> rtl/lead_predict_pan_aim_loop_top.sv
// Lead-predicting pan aim loop: one request in, one pan/aim result out.
// A zero predicted point skips the CORDIC normalization and rotation. One request
// at a time, taken only after the result of the last is registered; a stalled
// result delays only the next one's end. Time goes to the 56-step serial divider
// (five or seven passes) and the 21-step serial multiplier. Synchronous active-low
// reset restores control, configuration, motion state and output valid, not the datapath.
module lead_predict_pan_aim_loop_top import lpp_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lpp_in_if.sink                in_ch,
  lpp_out_if.source             out_ch
);

  localparam int IT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  // control
  state_t state_r, state_nxt;
  op_t    op_r;
  logic [1:0]       term_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IT_W-1:0]  it_r;

  // configuration
  logic [GAIN_W-1:0]       kp_r, kd_r;
  logic [DT_W-1:0]         lead_r, fb_r;
  logic signed [ANG_W-1:0] center_r, min_r, max_r;
  logic                    accel_r;

  // motion state
  logic signed [POS_W-1:0] prev_x_r, prev_y_r;
  logic signed [VEL_W-1:0] prev_vx_r, prev_vy_r;
  logic [TIME_W-1:0]       prev_t_r;
  logic signed [ANG_W-1:0] pan_now_r;

  // working registers
  logic signed [POS_W-1:0] x_r, y_r;
  logic [TIME_W-1:0]       t_r;
  logic [DT_W-1:0]         dt_r;
  logic signed [ACC_W-1:0] acc_r, mcand_r;
  logic [MPL_W-1:0]        mplier_r;
  logic [ACC_W-1:0]        num_r;
  logic [REM_W-1:0]        rem_r;
  logic [DEN_W-1:0]        den_r;
  logic                    qneg_r;
  logic signed [VEL_W-1:0] vx_r, vy_r, ax_r, ay_r;
  logic [MAG_W-1:0]        pxm_r, pym_r, mx_r, my_r;
  logic                    pxs_r, pys_r;
  logic signed [CX_W-1:0]  cx_r, cy_r;
  logic signed [Z_W-1:0]   z_r;
  logic signed [ANG_W-1:0] aim_r, pan_new_r;

  // output register
  logic                    out_valid_r;
  logic signed [ANG_W-1:0] out_pan_r, out_aim_r;

  logic in_rdy, fin_go, mac_last, div_last, last_term;

  // elapsed time with fallback
  logic [TIME_W-1:0] dt_diff;
  logic [DT_W-1:0]   dt_sel;
  always_comb begin
    dt_diff = in_ch.time_ms - prev_t_r;
    if (dt_diff == '0 || dt_diff > DT_MAX) begin
      dt_sel = (fb_r == '0) ? DT_W'(1) : fb_r;
    end else begin
      dt_sel = dt_diff[DT_W-1:0];
    end
  end

  // lead-time factors
  logic [MPL_W-1:0] lead_2000, lead_sq;
  logic [2*DT_W-1:0] lead_prod;
  assign lead_2000 = ({lead_r, 11'b0}) - MPL_W'({lead_r, 5'b0}) - MPL_W'({lead_r, 4'b0});
  assign lead_prod = lead_r * lead_r;
  assign lead_sq   = MPL_W'(lead_prod);

  // differences
  logic signed [POS_W:0]   dx, dy;
  logic signed [VEL_W:0]   dvx, dvy;
  logic signed [ANG_W:0]   err;
  assign dx  = $signed({x_r[POS_W-1], x_r}) - $signed({prev_x_r[POS_W-1], prev_x_r});
  assign dy  = $signed({y_r[POS_W-1], y_r}) - $signed({prev_y_r[POS_W-1], prev_y_r});
  assign dvx = $signed({vx_r[VEL_W-1], vx_r}) - $signed({prev_vx_r[VEL_W-1], prev_vx_r});
  assign dvy = $signed({vy_r[VEL_W-1], vy_r}) - $signed({prev_vy_r[VEL_W-1], prev_vy_r});
  assign err = $signed({aim_r[ANG_W-1], aim_r}) - $signed({pan_now_r[ANG_W-1], pan_now_r});

  // operand selection for the serial multiplier and the divider
  logic signed [ACC_W-1:0] mac_mcand, setup_acc;
  logic [MPL_W-1:0]        mac_mplier;
  logic [DEN_W-1:0]        den_sel;
  always_comb begin
    mac_mcand  = '0;
    mac_mplier = '0;
    setup_acc  = '0;
    den_sel    = DEN_W'(dt_r);
    case (op_r)
      OP_VX: setup_acc = times1000(ACC_W'(dx));
      OP_VY: setup_acc = times1000(ACC_W'(dy));
      OP_AX: setup_acc = times1000(ACC_W'(dvx));
      OP_AY: setup_acc = times1000(ACC_W'(dvy));
      OP_PX, OP_PY: begin
        den_sel = PRED_DIV;
        case (term_r)
          2'd0: begin
            mac_mcand  = (op_r == OP_PX) ? ACC_W'(x_r) : ACC_W'(y_r);
            mac_mplier = PRED_DIV;
          end
          2'd1: begin
            mac_mcand  = (op_r == OP_PX) ? ACC_W'(vx_r) : ACC_W'(vy_r);
            mac_mplier = lead_2000;
          end
          default: begin
            mac_mcand  = (op_r == OP_PX) ? ACC_W'(ax_r) : ACC_W'(ay_r);
            mac_mplier = lead_sq;
          end
        endcase
      end
      OP_STEP: begin
        den_sel = STEP_DIV;
        if (term_r == 2'd0) begin
          mac_mcand  = times1000(ACC_W'(err));
          mac_mplier = MPL_W'(kp_r);
        end else begin
          mac_mcand  = ACC_W'(dvx) <<< 7;
          mac_mplier = MPL_W'(kd_r);
        end
      end
      default: setup_acc = '0;
    endcase
  end

  // divider step
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  logic [ACC_W-1:0] acc_mag;
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[ACC_W-1]};
  assign rem_ge  = rem_sh >= REM_W'(den_r);
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // normalization window of the rotator operands
  logic [MAG_W-1:0] mm;
  logic mm_hi, mm_in;
  assign mm    = (mx_r > my_r) ? mx_r : my_r;
  assign mm_hi = |mm[MAG_W-1:NORM_HI];
  assign mm_in = !mm_hi && mm[NORM_LO];

  // rotator operand signs
  logic xneg, yneg;
  assign xneg = pys_r && (mx_r != '0);
  assign yneg = pxs_r && (my_r != '0);

  // rotator step
  logic signed [CX_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_v;
  assign xs     = cx_r >>> it_r;
  assign ys     = cy_r >>> it_r;
  assign atan_v = $signed(Z_W'(atan_lut(ATAN_IDX_W'(it_r))));

  // angle rounding, centering and clamping
  logic [Z_W-1:0]             z_abs, ang_mag;
  logic signed [ANG_W+1:0]    ang, aim_sum, aim_hi;
  always_comb begin
    z_abs   = z_r[Z_W-1] ? Z_W'(-z_r) : Z_W'(z_r);
    ang_mag = (z_abs + Z_ROUND) >> Z_SHIFT;
    ang     = z_r[Z_W-1] ? -$signed({1'b0, ang_mag[ANG_W:0]})
                         : $signed({1'b0, ang_mag[ANG_W:0]});
    aim_sum = (ANG_W+2)'(center_r) + ang;
    aim_hi  = (aim_sum > (ANG_W+2)'(max_r)) ? (ANG_W+2)'(max_r) : aim_sum;
    if (aim_hi < (ANG_W+2)'(min_r)) begin
      aim_hi = (ANG_W+2)'(min_r);
    end
  end

  // pan update with saturation
  logic signed [ANG_W+2:0] pan_sum;
  logic signed [ANG_W-1:0] pan_res;
  always_comb begin
    pan_sum = qneg_r ? (ANG_W+3)'(pan_now_r) - $signed({2'b0, num_r[ANG_W:0]})
                     : (ANG_W+3)'(pan_now_r) + $signed({2'b0, num_r[ANG_W:0]});
    if (|num_r[ACC_W-1:ANG_W+1]) begin
      pan_res = qneg_r ? PAN_MIN : PAN_MAX;
    end else if (pan_sum > (ANG_W+3)'(PAN_MAX)) begin
      pan_res = PAN_MAX;
    end else if (pan_sum < (ANG_W+3)'(PAN_MIN)) begin
      pan_res = PAN_MIN;
    end else begin
      pan_res = pan_sum[ANG_W-1:0];
    end
  end

  // sequencer outputs
  always_comb begin
    in_rdy    = (state_r == ST_IDLE);
    fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
    mac_last  = (cnt_r == CNT_W'(MPL_W - 1));
    div_last  = (cnt_r == CNT_W'(ACC_W - 1));
    if (op_r == OP_STEP) begin
      last_term = (term_r == (accel_r ? 2'd1 : 2'd0));
    end else begin
      last_term = (term_r == (accel_r ? 2'd2 : 2'd1));
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (op_r == OP_PX || op_r == OP_PY || op_r == OP_STEP) begin
          state_nxt = ST_MACLD;
        end else begin
          state_nxt = ST_DIVLD;
        end
      end
      ST_MACLD: state_nxt = ST_MAC;
      ST_MAC:   if (mac_last) state_nxt = last_term ? ST_DIVLD : ST_MACLD;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   if (div_last) state_nxt = ST_WB;
      ST_WB: begin
        if (op_r == OP_PY) begin
          state_nxt = ST_CLD;
        end else if (op_r == OP_STEP) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_CLD:   state_nxt = (pxm_r == '0 && pym_r == '0) ? ST_AIM : ST_CNORM;
      ST_CNORM: if (mm_in) state_nxt = ST_CPREP;
      ST_CPREP: state_nxt = ST_CITER;
      ST_CITER: if (it_r == IT_LAST) state_nxt = ST_AIM;
      ST_AIM:   state_nxt = ST_SETUP;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration, motion state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kp_r        <= KP_RST;
      kd_r        <= KD_RST;
      lead_r      <= LEAD_RST;
      fb_r        <= FALLBACK_RST;
      center_r    <= CENTER_RST;
      min_r       <= MIN_PAN_RST;
      max_r       <= MAX_PAN_RST;
      accel_r     <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_vx_r   <= '0;
      prev_vy_r   <= '0;
      prev_t_r    <= '0;
      pan_now_r   <= CENTER_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_KP:       kp_r     <= cfg_wdata;
          REG_KD:       kd_r     <= cfg_wdata;
          REG_LEAD:     lead_r   <= cfg_wdata[DT_W-1:0];
          REG_FALLBACK: fb_r     <= cfg_wdata[DT_W-1:0];
          REG_CENTER:   center_r <= $signed(cfg_wdata);
          REG_MIN_PAN:  min_r    <= $signed(cfg_wdata);
          REG_MAX_PAN:  max_r    <= $signed(cfg_wdata);
          REG_ACCEL:    accel_r  <= cfg_wdata[0];
          default:      accel_r  <= accel_r;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        prev_x_r    <= x_r;
        prev_y_r    <= y_r;
        prev_vx_r   <= vx_r;
        prev_vy_r   <= vy_r;
        prev_t_r    <= t_r;
        pan_now_r   <= pan_new_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_r  <= in_ch.pos_x;
          y_r  <= in_ch.pos_y;
          t_r  <= in_ch.time_ms;
          dt_r <= dt_sel;
          op_r <= OP_VX;
        end
      end
      ST_SETUP: begin
        term_r <= '0;
        acc_r  <= setup_acc;
      end
      ST_MACLD: begin
        mcand_r  <= mac_mcand;
        mplier_r <= mac_mplier;
        cnt_r    <= '0;
      end
      ST_MAC: begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + CNT_W'(1);
        if (mac_last) term_r <= term_r + 2'd1;
      end
      ST_DIVLD: begin
        qneg_r <= acc_r[ACC_W-1];
        num_r  <= acc_mag + ACC_W'(den_sel >> 1);
        den_r  <= den_sel;
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? rem_sh - REM_W'(den_r) : rem_sh;
        num_r <= {num_r[ACC_W-2:0], rem_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_WB: begin
        case (op_r)
          OP_VX: begin
            vx_r <= sat_vel(qneg_r, num_r);
            op_r <= OP_VY;
          end
          OP_VY: begin
            vy_r <= sat_vel(qneg_r, num_r);
            op_r <= accel_r ? OP_AX : OP_PX;
          end
          OP_AX: begin
            ax_r <= sat_vel(qneg_r, num_r);
            op_r <= OP_AY;
          end
          OP_AY: begin
            ay_r <= sat_vel(qneg_r, num_r);
            op_r <= OP_PX;
          end
          OP_PX: begin
            pxm_r <= num_r[MAG_W-1:0];
            pxs_r <= qneg_r;
            op_r  <= OP_PY;
          end
          OP_PY: begin
            pym_r <= num_r[MAG_W-1:0];
            pys_r <= qneg_r;
          end
          default: pan_new_r <= pan_res;
        endcase
      end
      // atan2(px, py): x axis is forward
      ST_CLD: begin
        mx_r <= pym_r;
        my_r <= pxm_r;
        z_r  <= '0;
      end
      ST_CNORM: begin
        if (mm_hi) begin
          mx_r <= mx_r >> 1;
          my_r <= my_r >> 1;
        end else if (!mm[NORM_LO]) begin
          mx_r <= mx_r << 1;
          my_r <= my_r << 1;
        end
      end
      // reflect the left half plane and seed the half-turn base
      ST_CPREP: begin
        cx_r <= $signed(mx_r[CX_W-1:0]);
        cy_r <= (xneg ^ yneg) ? -$signed(my_r[CX_W-1:0]) : $signed(my_r[CX_W-1:0]);
        z_r  <= xneg ? (yneg ? -HALF_TURN : HALF_TURN) : '0;
        it_r <= '0;
      end
      ST_CITER: begin
        if (!cy_r[CX_W-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          z_r  <= z_r + atan_v;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          z_r  <= z_r - atan_v;
        end
        it_r <= it_r + IT_W'(1);
      end
      ST_AIM: begin
        aim_r <= aim_hi[ANG_W-1:0];
        op_r  <= OP_STEP;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_pan_r <= pan_new_r;
          out_aim_r <= aim_r;
        end
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pan_angle = out_pan_r;
  assign out_ch.aim_angle = out_aim_r;

endmodule

>>> rtl/lpp_checker.sv
// lpp_checker: port-level assertions of the pan aim loop, bound to the top.
// Depends on lpp_pkg and lead_predict_pan_aim_loop_top.
module lpp_checker import lpp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ANG_W-1:0] out_pan_angle,
  input logic [ANG_W-1:0] out_aim_angle
);

  // busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after accepting a request");

  // ready drops only on an accepted request
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without a request");

  // a new result only at the end of work on a request
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pan_angle)
                                && $stable(out_aim_angle))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lead_predict_pan_aim_loop_top lpp_checker u_lpp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pan_angle (out_ch.pan_angle),
  .out_aim_angle (out_ch.aim_angle)
);
